/* rtl/core/arpue_pkg.sv */
// Shared types and constants for the ARP reply / UDP echo responder.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package arpue_pkg;

  localparam int DATA_W           = 64;
  localparam int CNT_W            = 4;
  localparam int IP_W             = 32;
  localparam int MAC_W            = 48;
  localparam int CFG_W            = 48;
  localparam int CFG_IDX_W        = 1;
  localparam int BYTES_PER_WORD   = 8;
  localparam int HEADER_WORDS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

  localparam logic [IP_W-1:0] OWN_IP_RST = 32'hc0a8640a;

  // frame constants
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQ    = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] ECHO_PORT     = 16'd7;
  localparam logic [7:0]  ECHO_TTL      = 8'h40;
  localparam int          ETH_HDR_LEN   = 14;
  localparam int          MIN_REPLY_LEN = 42;

  // one word as it travels from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;      // final word of the frame
    logic              hdr;       // word belongs to the held header
    logic              hdr_last;  // header is complete with this word
  } q_entry_t;

endpackage

`default_nettype wire

/* rtl/core/arpue_front.sv */
// Front end: accepts frame words, normalizes the byte count, zeroes dead
// bytes and tags each word by its place in the frame. Uses arpue_pkg.
`default_nettype none

module arpue_front #(
  parameter int HEADER_WORDS = arpue_pkg::HEADER_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [arpue_pkg::DATA_W-1:0]  in_frame_word,
  input  logic [arpue_pkg::CNT_W-1:0]   in_byte_count,
  input  logic                          in_frame_end,
  input  logic                          q_full,
  output logic                          q_push,
  output arpue_pkg::q_entry_t           q_data
);
  import arpue_pkg::*;

  localparam int CNTW = $clog2(HEADER_WORDS + 1);

  logic [CNTW-1:0]  idx_r;
  logic [CNTW-1:0]  idx_nxt;
  logic [CNT_W-1:0] cnt;
  logic             in_hdr;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign in_hdr = idx_r < CNTW'(HEADER_WORDS);

  always_comb begin
    if (!in_frame_end || in_byte_count == '0 || in_byte_count > CNT_W'(BYTES_PER_WORD)) begin
      cnt = CNT_W'(BYTES_PER_WORD);
    end else begin
      cnt = in_byte_count;
    end
  end

  always_comb begin
    q_data.word = '0;
    for (int k = 0; k < BYTES_PER_WORD; k++) begin
      if (CNT_W'(k) < cnt) begin
        q_data.word[DATA_W-1-8*k -: 8] = in_frame_word[DATA_W-1-8*k -: 8];
      end
    end
    q_data.count    = cnt;
    q_data.last     = in_frame_end;
    q_data.hdr      = in_hdr;
    q_data.hdr_last = in_hdr && (in_frame_end || idx_r == CNTW'(HEADER_WORDS - 1));
  end

  // count header words; saturate past the header until the frame ends
  always_comb begin
    idx_nxt = idx_r;
    if (q_push) begin
      if (in_frame_end) begin
        idx_nxt = '0;
      end else if (in_hdr) begin
        idx_nxt = idx_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/arpue_fifo.sv */
// Short word queue between the front and the back end.
// Uses arpue_pkg for the entry type.
`default_nettype none

module arpue_fifo #(
  parameter int DEPTH = arpue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  arpue_pkg::q_entry_t  wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output arpue_pkg::q_entry_t  rd_data,
  output logic                 empty
);
  import arpue_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/arpue_back.sv */
// Back end: holds the header, judges and rewrites it, recomputes the IPv4
// header checksum a word per cycle and drives the output register. Uses arpue_pkg.
`default_nettype none

module arpue_back #(
  parameter int HEADER_WORDS = arpue_pkg::HEADER_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [arpue_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpue_pkg::CFG_W-1:0]      cfg_wdata,
  input  arpue_pkg::q_entry_t              q_data,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  output logic [arpue_pkg::DATA_W-1:0]     out_word,
  output logic [arpue_pkg::CNT_W-1:0]      out_count,
  output logic                             out_end,
  input  logic                             out_take
);
  import arpue_pkg::*;

  localparam int IDXW      = $clog2(HEADER_WORDS);
  localparam int CNTW      = $clog2(HEADER_WORDS + 1);
  localparam int LENW      = $clog2(HEADER_WORDS * BYTES_PER_WORD + 1);
  localparam int POSW      = IDXW + 3;
  localparam int NSW       = IDXW + 4;
  localparam int REW_WORDS = 6;
  localparam int REW_BYTES = REW_WORDS * BYTES_PER_WORD;
  localparam int CSUM_WORD = 3;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_CKSUM   = 3'd2;
  localparam logic [2:0] S_CKFIN   = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [DATA_W-1:0] store_r [HEADER_WORDS];
  logic [CNTW-1:0]   wr_cnt_r;
  logic [CNT_W-1:0]  last_bytes_r;
  logic              end_seen_r;
  logic              pass_r;
  logic [IDXW-1:0]   ck_idx_r;
  logic [IDXW-1:0]   em_idx_r;
  logic [20:0]       acc_r;
  logic [6:0]        end_byte_r;
  logic [IP_W-1:0]   own_ip_r;
  logic [MAC_W-1:0]  own_mac_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_word_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_end_r;

  logic [7:0]        hb [REW_BYTES];
  logic [7:0]        nb [REW_BYTES];
  logic [DATA_W-1:0] rew [REW_WORDS];
  logic [LENW-1:0]   len;
  logic [15:0]       etype;
  logic [5:0]        hl;
  logic [6:0]        end_byte;
  logic              len_ok;
  logic              is_arp;
  logic              is_udp;
  logic              answer;
  logic [IDXW-1:0]   rd_idx;
  logic [DATA_W-1:0] rd_word;
  logic [POSW-1:0]   pos;
  logic [17:0]       part_sum;
  logic [20:0]       acc_nxt;
  logic [NSW-1:0]    nstart;
  logic              ck_done;
  logic [16:0]       fold1;
  logic [16:0]       fold2;
  logic [15:0]       csum;
  logic              em_last;
  logic              out_free;
  logic              pass_load;
  logic              emit_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= OWN_IP_RST;
      own_mac_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OWN_IP:  own_ip_r  <= cfg_wdata[IP_W-1:0];
        REG_OWN_MAC: own_mac_r <= cfg_wdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // judge the held header from fixed byte places
  always_comb begin
    for (int w = 0; w < REW_WORDS; w++) begin
      for (int k = 0; k < BYTES_PER_WORD; k++) begin
        hb[8*w+k] = store_r[w][DATA_W-1-8*k -: 8];
      end
    end
    len      = LENW'({wr_cnt_r - CNTW'(1), 3'b000}) + LENW'(last_bytes_r);
    etype    = {hb[12], hb[13]};
    hl       = {hb[14][3:0], 2'b00};
    end_byte = 7'(ETH_HDR_LEN) + 7'(hl);
    len_ok   = len >= LENW'(ETH_HDR_LEN);
    is_arp   = len_ok && etype == ETH_TYPE_ARP && len >= LENW'(MIN_REPLY_LEN)
               && {hb[20], hb[21]} == ARP_OP_REQ
               && {hb[38], hb[39], hb[40], hb[41]} == own_ip_r;
    is_udp   = len_ok && etype == ETH_TYPE_IPV4 && len >= LENW'(MIN_REPLY_LEN)
               && {1'b0, len} >= (LENW+1)'(end_byte)
               && hb[23] == IP_PROTO_UDP && {hb[36], hb[37]} == ECHO_PORT;
    answer   = is_arp || is_udp;
  end

  // rewrite the first words; every move reads the original bytes
  always_comb begin
    for (int i = 0; i < REW_BYTES; i++) begin
      nb[i] = hb[i];
    end
    if (is_arp) begin
      for (int k = 0; k < 6; k++) begin
        nb[k]    = hb[6+k];
        nb[6+k]  = own_mac_r[MAC_W-1-8*k -: 8];
        nb[32+k] = hb[22+k];
        nb[22+k] = own_mac_r[MAC_W-1-8*k -: 8];
      end
      for (int k = 0; k < 4; k++) begin
        nb[38+k] = hb[28+k];
        nb[28+k] = own_ip_r[IP_W-1-8*k -: 8];
      end
      nb[20] = ARP_OP_REPLY[15:8];
      nb[21] = ARP_OP_REPLY[7:0];
    end else begin
      // swap ports, IPs and MACs; set the TTL; clear UDP and IP checksums
      for (int k = 0; k < 2; k++) begin
        nb[34+k] = hb[36+k];
        nb[36+k] = hb[34+k];
      end
      nb[40] = 8'h00;
      nb[41] = 8'h00;
      for (int k = 0; k < 4; k++) begin
        nb[26+k] = hb[30+k];
        nb[30+k] = hb[26+k];
      end
      nb[22] = ECHO_TTL;
      nb[24] = 8'h00;
      nb[25] = 8'h00;
      for (int k = 0; k < 6; k++) begin
        nb[k]   = hb[6+k];
        nb[6+k] = hb[k];
      end
    end
    for (int w = 0; w < REW_WORDS; w++) begin
      for (int k = 0; k < BYTES_PER_WORD; k++) begin
        rew[w][DATA_W-1-8*k -: 8] = nb[8*w+k];
      end
    end
  end

  // checksum: add the 16-bit fields of one word that lie in the IP header
  assign rd_idx  = (state_r == S_CKSUM) ? ck_idx_r : em_idx_r;
  assign rd_word = store_r[rd_idx];

  always_comb begin
    part_sum = '0;
    pos      = '0;
    for (int j = 0; j < 4; j++) begin
      pos = POSW'({ck_idx_r, 3'b000}) + POSW'(2 * j);
      if (pos >= POSW'(ETH_HDR_LEN) && {1'b0, pos} < (POSW+1)'(end_byte_r)) begin
        part_sum = part_sum + 18'(rd_word[DATA_W-1-16*j -: 16]);
      end
    end
    acc_nxt = acc_r + 21'(part_sum);
    nstart  = {1'b0, ck_idx_r, 3'b000} + NSW'(BYTES_PER_WORD);
    ck_done = nstart >= NSW'(end_byte_r) || ck_idx_r == IDXW'(HEADER_WORDS - 1);
    fold1   = 17'(acc_r[15:0]) + 17'(acc_r[20:16]);
    fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
    csum    = ~fold2[15:0];
  end

  assign em_last   = CNTW'(em_idx_r) == wr_cnt_r - CNTW'(1);
  assign out_free  = !out_valid_r || out_take;
  assign q_pop     = state_r == S_COLLECT && !q_empty
                     && (q_data.hdr || !pass_r || out_free);
  assign pass_load = q_pop && !q_data.hdr && pass_r;
  assign emit_load = state_r == S_EMIT && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT: if (q_pop && q_data.hdr && q_data.hdr_last) begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!answer) begin
          state_nxt = S_COLLECT;
        end else if (is_arp) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CKSUM;
        end
      end
      S_CKSUM: if (ck_done) begin
        state_nxt = S_CKFIN;
      end
      S_CKFIN: state_nxt = S_EMIT;
      S_EMIT: if (emit_load && em_last) begin
        state_nxt = S_COLLECT;
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  // header store: no reset, only entries of the current frame are read
  always_ff @(posedge clk) begin
    if (state_r == S_COLLECT && q_pop && q_data.hdr) begin
      store_r[wr_cnt_r[IDXW-1:0]] <= q_data.word;
    end else if (state_r == S_DECIDE && answer) begin
      for (int w = 0; w < REW_WORDS; w++) begin
        store_r[w] <= rew[w];
      end
    end else if (state_r == S_CKFIN) begin
      store_r[CSUM_WORD][DATA_W-1 -: 16] <= csum;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      end_byte_r <= end_byte;
      acc_r      <= '0;
    end else if (state_r == S_CKSUM) begin
      acc_r      <= acc_nxt;
    end
    if (pass_load) begin
      out_word_r  <= q_data.word;
      out_count_r <= q_data.count;
      out_end_r   <= q_data.last;
    end else if (emit_load) begin
      out_word_r  <= rd_word;
      out_count_r <= (em_last && end_seen_r) ? last_bytes_r : CNT_W'(BYTES_PER_WORD);
      out_end_r   <= em_last && end_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_COLLECT;
      wr_cnt_r     <= '0;
      last_bytes_r <= '0;
      end_seen_r   <= 1'b0;
      pass_r       <= 1'b0;
      ck_idx_r     <= '0;
      em_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_COLLECT: begin
          if (q_pop && q_data.hdr) begin
            wr_cnt_r     <= wr_cnt_r + CNTW'(1);
            last_bytes_r <= q_data.count;
            end_seen_r   <= q_data.last;
          end else if (q_pop && q_data.last) begin
            // frame tail passed or dropped: back to header collection
            pass_r <= 1'b0;
          end
        end
        S_DECIDE: begin
          ck_idx_r <= IDXW'(1);
          em_idx_r <= '0;
          if (!answer) begin
            wr_cnt_r <= '0;
            pass_r   <= 1'b0;
          end
        end
        S_CKSUM: ck_idx_r <= ck_idx_r + IDXW'(1);
        S_CKFIN: ;
        S_EMIT: begin
          if (emit_load) begin
            em_idx_r <= em_idx_r + IDXW'(1);
            if (em_last) begin
              wr_cnt_r <= '0;
              pass_r   <= !end_seen_r;
            end
          end
        end
        default: ;
      endcase
      if (pass_load || emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_count = out_count_r;
  assign out_end   = out_end_r;

endmodule

`default_nettype wire

/* rtl/core/arp_reply_udp_echo_responder_core.sv */
// Top level of the ARP reply / UDP echo responder: front end, word queue and
// back end. Uses arpue_pkg, arpue_front, arpue_fifo and arpue_back.
//
//   channel   ports                                          handshake
//   input     in_frame_word, in_byte_count, in_frame_end      push / full
//   result    out_word, out_count, out_end                    pop / empty
//   config    cfg_index, cfg_wdata                            cfg_wr_en
//
// Words enter the queue at one per cycle while it has room. The back end
// stores header words at one per cycle, judges the header, then for UDP
// echo sums the header words up to the end of the IP header and folds the
// checksum, then emits the header words; later words of an answered frame
// pass at one per cycle unless the result side stalls. Reset is synchronous;
// the queue absorbs input while the back end judges or the result side stalls.
`default_nettype none

module arp_reply_udp_echo_responder_core #(
  parameter int HEADER_WORDS = arpue_pkg::HEADER_WORDS_DEF,
  parameter int QUEUE_DEPTH  = arpue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [arpue_pkg::DATA_W-1:0]     in_frame_word,
  input  logic [arpue_pkg::CNT_W-1:0]      in_byte_count,
  input  logic                             in_frame_end,
  output logic                             empty,
  input  logic                             pop,
  output logic [arpue_pkg::DATA_W-1:0]     out_word,
  output logic [arpue_pkg::CNT_W-1:0]      out_count,
  output logic                             out_end,
  input  logic                             cfg_wr_en,
  input  logic [arpue_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpue_pkg::CFG_W-1:0]      cfg_wdata
);
  import arpue_pkg::*;

  q_entry_t q_wr_data;
  q_entry_t q_rd_data;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  logic     out_valid;

  arpue_front #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_frame_word (in_frame_word),
    .in_byte_count (in_byte_count),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  arpue_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  arpue_back #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_data    (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_count (out_count),
    .out_end   (out_end),
    .out_take  (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

/* rtl/core/arpue_checker.sv */
// Port-level checks for the responder top level, bound to every instance.
// Depends on arpue_pkg and arp_reply_udp_echo_responder_core.
`default_nettype none

module arpue_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          full,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [arpue_pkg::DATA_W-1:0]  out_word,
  input  logic [arpue_pkg::CNT_W-1:0]   out_count,
  input  logic                          out_end
);
  import arpue_pkg::*;

  // reset leaves no result waiting and room for input
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("result or full flag survives reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_word) && $stable(out_count) && $stable(out_end))
    else $error("waiting result changed before it was taken");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_count != '0 && out_count <= CNT_W'(BYTES_PER_WORD))
    else $error("result byte count out of range");

  // only the final word of a frame may be short
  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_count != CNT_W'(BYTES_PER_WORD) |-> out_end)
    else $error("short word without end of frame");

endmodule

bind arp_reply_udp_echo_responder_core arpue_checker u_arpue_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_word  (out_word),
  .out_count (out_count),
  .out_end   (out_end)
);

`default_nettype wire

/* tb/tb_arp_reply_udp_echo_responder_core.sv */
// Testbench for arp_reply_udp_echo_responder_core: sends Ethernet frames as
// word streams, predicts the ARP replies and UDP echoes, checks every result word.
// Depends on arpue_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_arp_reply_udp_echo_responder_core;
  import arpue_pkg::*;

  localparam int HDR_WORDS    = HEADER_WORDS_DEF;
  localparam int HDR_BYTES    = HDR_WORDS * 8;
  localparam int DRAIN_CYCLES = 64;

  typedef enum logic [1:0] {COLLECTING, ANSWERING, DISCARDING} frame_state_e;

  typedef struct {
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;
  } reply_word_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               push          = 1'b0;
  logic [DATA_W-1:0]  in_frame_word = '0;
  logic [CNT_W-1:0]   in_byte_count = '0;
  logic               in_frame_end  = 1'b0;
  logic               pop           = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]   cfg_wdata     = '0;
  logic               full;
  logic               empty;
  logic [DATA_W-1:0]  out_word;
  logic [CNT_W-1:0]   out_count;
  logic               out_end;

  arp_reply_udp_echo_responder_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_frame_word(in_frame_word),
    .in_byte_count(in_byte_count),
    .in_frame_end (in_frame_end),
    .empty        (empty),
    .pop          (pop),
    .out_word     (out_word),
    .out_count    (out_count),
    .out_end      (out_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // responder state as predicted
  logic [IP_W-1:0]   own_ip_q  = OWN_IP_RST;
  logic [MAC_W-1:0]  own_mac_q = '0;
  logic [DATA_W-1:0] held_hdr [HDR_WORDS];
  int unsigned       held_cnt  = 0;
  int unsigned       tail_bytes = 0;
  frame_state_e      fstate    = COLLECTING;
  logic [7:0]        hdr_bytes [HDR_BYTES];

  reply_word_t reply_q [$];
  int unsigned reply_words = 0;
  int unsigned sent_words  = 0;
  int unsigned err_count   = 0;
  int unsigned rx_index    = 0;
  bit          idle_on     = 1'b1;
  int unsigned stall_left  = 0;

  // frame under construction
  logic [7:0] pkt [256];
  int         pkt_len;

  task automatic flag_error(input string what);
    $display("ERROR @%0t word %0d: %s", $time, rx_index, what);
    err_count++;
  endtask

  function automatic logic [DATA_W-1:0] keep_bytes(logic [DATA_W-1:0] w, int unsigned n);
    if (n >= 8) return w;
    return w & ~({DATA_W{1'b1}} >> (n * 8));
  endfunction

  function automatic logic [15:0] hdr16(int off);
    return {hdr_bytes[off], hdr_bytes[off+1]};
  endfunction

  function automatic void swap_hdr(int a, int c, int n);
    logic [7:0] t;
    for (int i = 0; i < n; i++) begin
      t = hdr_bytes[a+i];
      hdr_bytes[a+i] = hdr_bytes[c+i];
      hdr_bytes[c+i] = t;
    end
  endfunction

  // Judge the held header and rewrite it in place; 1 means answer the frame.
  function automatic bit rewrite_header(int unsigned len);
    int unsigned hl;
    logic [31:0] sum;
    logic [15:0] etype;
    if (len < ETH_HDR_LEN) return 1'b0;
    etype = hdr16(12);
    if (etype == ETH_TYPE_ARP) begin
      if (len < MIN_REPLY_LEN) return 1'b0;
      if (hdr16(20) != ARP_OP_REQ || {hdr16(38), hdr16(40)} != own_ip_q) return 1'b0;
      for (int i = 0; i < 6; i++) hdr_bytes[i] = hdr_bytes[6+i];
      for (int i = 0; i < 6; i++) hdr_bytes[6+i] = own_mac_q[47-8*i -: 8];
      hdr_bytes[20] = ARP_OP_REPLY[15:8];
      hdr_bytes[21] = ARP_OP_REPLY[7:0];
      // old sender becomes target before the sender fields are overwritten
      for (int i = 0; i < 6; i++) hdr_bytes[32+i] = hdr_bytes[22+i];
      for (int i = 0; i < 4; i++) hdr_bytes[38+i] = hdr_bytes[28+i];
      for (int i = 0; i < 6; i++) hdr_bytes[22+i] = own_mac_q[47-8*i -: 8];
      for (int i = 0; i < 4; i++) hdr_bytes[28+i] = own_ip_q[31-8*i -: 8];
      return 1'b1;
    end
    if (etype == ETH_TYPE_IPV4) begin
      hl = hdr_bytes[14][3:0] * 4;
      if (len < MIN_REPLY_LEN || len < ETH_HDR_LEN + hl) return 1'b0;
      if (hdr_bytes[23] != IP_PROTO_UDP || hdr16(36) != ECHO_PORT) return 1'b0;
      swap_hdr(34, 36, 2);
      hdr_bytes[40] = 8'h00;
      hdr_bytes[41] = 8'h00;
      swap_hdr(26, 30, 4);
      hdr_bytes[22] = ECHO_TTL;
      hdr_bytes[24] = 8'h00;
      hdr_bytes[25] = 8'h00;
      sum = '0;
      for (int unsigned i = 0; i < hl; i += 2) sum += hdr16(14 + i);
      while (sum[31:16] != 0) sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
      hdr_bytes[24] = ~sum[15:8];
      hdr_bytes[25] = ~sum[7:0];
      swap_hdr(0, 6, 6);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the prediction by one accepted input word.
  function automatic void track_frame_word(logic [DATA_W-1:0] w, logic [CNT_W-1:0] bc,
                                           logic fe);
    int unsigned cnt;
    int unsigned n;
    logic [DATA_W-1:0] kw;
    logic [DATA_W-1:0] ow;
    reply_word_t r;
    cnt = fe ? ((bc == 0 || bc > 8) ? 8 : bc) : 8;
    kw = keep_bytes(w, cnt);
    if (fstate == ANSWERING) begin
      r.word = kw; r.count = CNT_W'(cnt); r.last = fe;
      reply_q.push_back(r);
      reply_words++;
      if (fe) fstate = COLLECTING;
      return;
    end
    if (fstate == DISCARDING) begin
      if (fe) fstate = COLLECTING;
      return;
    end
    if (held_cnt >= HDR_WORDS) held_cnt = 0;
    held_hdr[held_cnt] = kw;
    held_cnt++;
    tail_bytes = cnt;
    if (!(fe || held_cnt == HDR_WORDS)) return;
    n = held_cnt;
    held_cnt = 0;
    for (int i = 0; i < HDR_BYTES; i++) hdr_bytes[i] = 8'h00;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < 8; j++) hdr_bytes[i*8+j] = held_hdr[i][63-8*j -: 8];
    if (!rewrite_header((n - 1) * 8 + tail_bytes)) begin
      fstate = fe ? COLLECTING : DISCARDING;
      return;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 8; j++) ow[63-8*j -: 8] = hdr_bytes[i*8+j];
      r.word  = ow;
      r.last  = fe && (i + 1 == n);
      r.count = r.last ? CNT_W'(tail_bytes) : CNT_W'(8);
      reply_q.push_back(r);
      reply_words++;
    end
    fstate = fe ? COLLECTING : ANSWERING;
  endfunction

  // result side: check each popped word, stall pop in random bursts while idle_on is set
  always @(posedge clk) begin
    reply_word_t e;
    if (rst_n && pop && !empty) begin
      if (reply_q.size() == 0) begin
        flag_error($sformatf("unexpected word %h", out_word));
      end else begin
        e = reply_q.pop_front();
        if (out_word !== e.word)
          flag_error($sformatf("out_word %h, want %h", out_word, e.word));
        if (out_count !== e.count)
          flag_error($sformatf("out_count %0d, want %0d", out_count, e.count));
        if (out_end !== e.last)
          flag_error($sformatf("out_end %b, want %b", out_end, e.last));
      end
      rx_index++;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Push one word; push stays high afterwards so back-to-back words need no gap.
  task automatic send_word(input logic [DATA_W-1:0] w, input logic [CNT_W-1:0] bc,
                           input logic fe);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push          <= 1'b1;
    in_frame_word <= w;
    in_byte_count <= bc;
    in_frame_end  <= fe;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_words++;
    track_frame_word(w, bc, fe);
  endtask

  // Cut pkt into words; junk fills dead bytes and uses don't-care byte counts.
  task automatic send_frame(input bit junk);
    int nw;
    int nb;
    int v;
    logic [DATA_W-1:0] w;
    logic [CNT_W-1:0] bc;
    nw = (pkt_len + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      nb = (pkt_len - k * 8 > 8) ? 8 : pkt_len - k * 8;
      for (int j = 0; j < 8; j++)
        w[63-8*j -: 8] = (j < nb) ? pkt[k*8+j] : (junk ? 8'($urandom) : 8'h00);
      if (k != nw - 1) begin
        bc = junk ? CNT_W'($urandom_range(0, 15)) : CNT_W'(8);
      end else if (nb == 8 && junk) begin
        v = $urandom_range(8, 16);
        bc = (v == 16) ? CNT_W'(0) : CNT_W'(v);
      end else begin
        bc = CNT_W'(nb);
      end
      send_word(w, bc, k == nw - 1);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers; the block is idle when this is called.
  task automatic set_config(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    logic [CFG_W-IP_W-1:0] upper;
    upper = 16'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_OWN_IP;
    cfg_wdata <= {upper, ip};
    @(posedge clk);
    own_ip_q = ip;
    cfg_index <= REG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    own_mac_q = mac;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void fill_random(int n);
    pkt_len = n;
    for (int i = 0; i < n; i++) pkt[i] = 8'($urandom);
  endfunction

  function automatic void set_be(int off, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) pkt[off+n-1-i] = v[8*i +: 8];
  endfunction

  function automatic void build_arp(logic [IP_W-1:0] tgt, logic [15:0] op, int len);
    fill_random(len);
    if ($urandom_range(0, 1)) set_be(0, 6, 48'hffff_ffff_ffff);
    set_be(12, 2, ETH_TYPE_ARP);
    if (len >= 22) set_be(20, 2, op);
    if (len >= 42) set_be(38, 4, tgt);
  endfunction

  function automatic void build_udp(logic [3:0] ihl, logic [7:0] proto, logic [15:0] dport,
                                    int len);
    fill_random(len);
    set_be(12, 2, ETH_TYPE_IPV4);
    if (len > 14) pkt[14] = {4'h4, ihl};
    if (len > 23) pkt[23] = proto;
    if (len >= 38) set_be(36, 2, dport);
  endfunction

  function automatic int udp_min_len(logic [3:0] ihl);
    return (14 + ihl * 4 > MIN_REPLY_LEN) ? 14 + ihl * 4 : MIN_REPLY_LEN;
  endfunction

  task automatic test_reset_values();
    build_arp(OWN_IP_RST, ARP_OP_REQ, 42);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_arp_request();
    build_arp(own_ip_q, ARP_OP_REPLY, 42);
    send_frame(1'b0);
    build_arp(own_ip_q ^ 32'h1, ARP_OP_REQ, 48);
    send_frame(1'b0);
    build_arp(own_ip_q, ARP_OP_REQ, 48);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_udp_echo();
    build_udp(4'd5, IP_PROTO_UDP, ECHO_PORT, 42);
    send_frame(1'b0);
    // ihl of zero: empty checksum span, field still written
    build_udp(4'd0, IP_PROTO_UDP, ECHO_PORT, 48);
    send_frame(1'b1);
    // longer than the header store: tail words pass straight through
    build_udp(4'd5, IP_PROTO_UDP, ECHO_PORT, 100);
    send_frame(1'b1);
    // long frame that is dropped, then a reply right behind it
    build_udp(4'd5, IP_PROTO_UDP, 16'd8, 90);
    send_frame(1'b0);
    build_udp(4'd15, IP_PROTO_UDP, ECHO_PORT, 74);
    send_frame(1'b0);
    settle();
  endtask

  task automatic test_short_frames();
    fill_random(13);
    send_frame(1'b0);
    build_arp(own_ip_q, ARP_OP_REQ, 41);
    send_frame(1'b1);
    build_udp(4'd15, IP_PROTO_UDP, ECHO_PORT, 73);
    send_frame(1'b0);
    settle();
  endtask

  task automatic test_config_extremes();
    set_config('0, {MAC_W{1'b1}});
    build_arp('0, ARP_OP_REQ, 42);
    send_frame(1'b0);
    build_arp(OWN_IP_RST, ARP_OP_REQ, 42);
    send_frame(1'b0);
    settle();
    set_config({IP_W{1'b1}}, '0);
    build_arp({IP_W{1'b1}}, ARP_OP_REQ, 42);
    send_frame(1'b1);
    settle();
    set_config($urandom, {16'($urandom), 32'($urandom)});
    build_arp(own_ip_q, ARP_OP_REQ, 46);
    send_frame(1'b0);
    settle();
  endtask

  task automatic send_random_frame();
    int r;
    logic [3:0] ihl;
    logic [15:0] v16;
    r = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    if (r < 35) begin
      build_arp(own_ip_q, ARP_OP_REQ, ($urandom_range(0, 9) == 0) ?
                $urandom_range(80, 140) : $urandom_range(42, 62));
    end else if (r < 70) begin
      build_udp(ihl, IP_PROTO_UDP, ECHO_PORT, udp_min_len(ihl) + (($urandom_range(0, 9) == 0)
                ? $urandom_range(0, 100) : $urandom_range(0, 16)));
    end else if (r < 78) begin
      case ($urandom_range(0, 2))
        0: begin
          v16 = 16'($urandom);
          if (v16 == ARP_OP_REQ) v16 = ARP_OP_REPLY;
          build_arp(own_ip_q, v16, $urandom_range(42, 90));
        end
        1: build_arp(own_ip_q ^ (32'h1 << $urandom_range(0, 31)), ARP_OP_REQ,
                     $urandom_range(42, 90));
        default: build_arp(own_ip_q, ARP_OP_REQ, $urandom_range(14, 41));
      endcase
    end else if (r < 86) begin
      case ($urandom_range(0, 2))
        0: begin
          v16 = 16'($urandom);
          if (v16 == ECHO_PORT) v16 = 16'd9;
          build_udp(ihl, IP_PROTO_UDP, v16, udp_min_len(ihl) + $urandom_range(0, 40));
        end
        1: build_udp(ihl, 8'd6, ECHO_PORT, udp_min_len(ihl) + $urandom_range(0, 40));
        default: build_udp(ihl, IP_PROTO_UDP, ECHO_PORT,
                           $urandom_range(14, udp_min_len(ihl) - 1));
      endcase
    end else begin
      fill_random($urandom_range(1, 100));
      if (pkt_len >= 14 && $urandom_range(0, 1))
        set_be(12, 2, $urandom_range(0, 1) ? ETH_TYPE_ARP : ETH_TYPE_IPV4);
    end
    send_frame($urandom_range(0, 3) == 0);
  endtask

  // Mostly answerable frames until about target input words went in;
  // reconfigure now and then between bursts.
  task automatic test_random_traffic(input int unsigned target, input bit idle);
    int unsigned start;
    int unsigned frames;
    logic [IP_W-1:0] ip;
    logic [MAC_W-1:0] mac;
    settle();
    idle_on = idle;
    start = sent_words;
    frames = 0;
    while (sent_words - start < target) begin
      if (frames % 10 == 9) begin
        settle();
        case ($urandom_range(0, 3))
          0: ip = '0;
          1: ip = {IP_W{1'b1}};
          2: ip = OWN_IP_RST;
          default: ip = $urandom;
        endcase
        case ($urandom_range(0, 2))
          0: mac = '0;
          1: mac = {MAC_W{1'b1}};
          default: mac = {16'($urandom), 32'($urandom)};
        endcase
        set_config(ip, mac);
      end
      send_random_frame();
      frames++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_arp_request();
    test_udp_echo();
    test_short_frames();
    test_config_extremes();
    test_random_traffic(220, 1'b1);
    test_random_traffic(150, 1'b0);
    settle();
    if (err_count == 0 && reply_q.size() == 0) begin
      $display("tb_arp_reply_udp_echo_responder_core: done, clean");
    end else begin
      $display("tb_arp_reply_udp_echo_responder_core: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_arp_reply_udp_echo_responder_core: done, errors");
    $finish;
  end

endmodule
